/* rtl/core/spq_pkg.sv */
// types and codes shared by the sorted priority queue
// no dependencies; imported by spq_cell and sorted_priority_queue
package spq_pkg;

  localparam int KEY_W   = 32;
  localparam int ENTRY_W = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    func_t                    func;
    logic signed [KEY_W-1:0]  key_in;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  max_key;
    logic                     has_max;
    logic [ENTRY_W-1:0]       entry_total;
    status_t                  status;
  } rsp_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cmd_t;

endpackage

/* rtl/core/sorted_priority_queue.sv */
// sorted max-priority queue built from a chain of key cells
// depends on spq_pkg and spq_cell
//
// usage: each req word either inserts key_in or removes the maximum. every
// accepted req word yields exactly one rsp word giving the head key, a
// nonempty flag, the entry count and a status code after the operation.
// keys are kept in descending order across CAPACITY cells; on insert every
// cell compares its key with the new one in the same cycle and either holds,
// takes the new key or takes its left neighbor, on remove every cell takes
// its right neighbor. a new key goes ahead of equal stored keys.
// latency: the rsp word is valid the cycle after the req word is accepted.
// throughput: one word per cycle while no rsp word is held by rsp_stall, set by the cell update.
// remove on empty and insert on full leave the store alone and report it
// in status. reset clears the entry count and rsp_valid; cell contents and
// the rsp payload are not reset and only occupied cells are ever read.
// while rsp_stall holds a waiting rsp word, req_stall is raised so no new
// word enters; the rsp word is held unchanged.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  cmd_t                    cmd;
  status_t                 status_next;
  rsp_t                    rsp_next;
  logic signed [KEY_W-1:0] head_next;

  logic signed [KEY_W-1:0] keys     [CAPACITY];
  logic                    ges      [CAPACITY];
  logic signed [KEY_W-1:0] lefts    [CAPACITY];
  logic                    left_ges [CAPACITY];
  logic signed [KEY_W-1:0] rights   [CAPACITY];
  logic                    occs     [CAPACITY];

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign is_full   = (count == CW'(CAPACITY));
  assign is_empty  = (count == '0);

  assign cmd.insert = accept && (req.func == FUNC_INSERT) && !is_full;
  assign cmd.remove = accept && (req.func == FUNC_REMOVE) && !is_empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occs[i] = (count > CW'(i));
    if (i == 0) begin : g_head
      assign lefts[i]    = req.key_in;
      assign left_ges[i] = 1'b0;
    end else begin : g_body
      assign lefts[i]    = keys[i-1];
      assign left_ges[i] = ges[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rights[i] = keys[i];
    end else begin : g_mid
      assign rights[i] = keys[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_key   (req.key_in),
      .occupied  (occs[i]),
      .left_key  (lefts[i]),
      .left_ge   (left_ges[i]),
      .right_key (rights[i]),
      .key       (keys[i]),
      .ge        (ges[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    head_next   = keys[0];
    if (cmd.insert) begin
      count_next = count + 1'b1;
      if (!ges[0]) begin
        head_next = req.key_in;
      end
    end else if (cmd.remove) begin
      count_next = count - 1'b1;
      head_next  = keys[1];
    end
    if (accept && (req.func == FUNC_INSERT) && is_full) begin
      status_next = ST_FULL;
    end else if (accept && (req.func == FUNC_REMOVE) && is_empty) begin
      status_next = ST_EMPTY;
    end
  end

  always_comb begin
    rsp_next.has_max     = (count_next != '0);
    rsp_next.max_key     = rsp_next.has_max ? head_next : '0;
    rsp_next.entry_total = ENTRY_W'(count_next);
    rsp_next.status      = status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted word produced no rsp word");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_FULL)) |-> is_full)
    else $error("full status while queue not full");

  a_has_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.has_max == !is_empty))
    else $error("has_max disagrees with entry count");

endmodule

/* rtl/core/spq_cell.sv */
// one storage cell of the sorted register chain
// depends on spq_pkg
module spq_cell (
  input  logic                            clk,
  input  spq_pkg::cmd_t                   cmd,
  input  logic signed [spq_pkg::KEY_W-1:0] new_key,
  input  logic                            occupied,
  input  logic signed [spq_pkg::KEY_W-1:0] left_key,
  input  logic                            left_ge,
  input  logic signed [spq_pkg::KEY_W-1:0] right_key,
  output logic signed [spq_pkg::KEY_W-1:0] key,
  output logic                            ge
);
  import spq_pkg::*;

  logic signed [KEY_W-1:0] key_next;

  // stored key stays ahead of the new one only when strictly greater
  assign ge = occupied && (key > new_key);

  always_comb begin
    key_next = key;
    if (cmd.insert) begin
      if (!ge) begin
        key_next = left_ge ? new_key : left_key;
      end
    end else if (cmd.remove) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

/* test/sorted_priority_queue_tb.sv */
// self-checking testbench for sorted_priority_queue: directed table, then random words
// keeps a shadow sorted store to predict every rsp word; depends on spq_pkg and the rtl
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int RANDOM_PER_PHASE = 570;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int LIMIT = 200000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  typedef struct {
    req_t w;
    bit   pin;
    rsp_t want;
  } row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // pinned rsp travels with the req word so the monitor sees the matching one
  bit   pinned;
  rsp_t pinned_rsp;

  row_t plan [$];
  rsp_t due_rsp [$];

  logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
  int shadow_count;

  int snd_idle;
  int rcv_idle;
  bit hold_req;
  int cycles;
  int mismatches;
  int words_in;
  int words_out;
  int full_hits;
  int empty_hits;

  sorted_priority_queue #(.CAPACITY(CAPACITY)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // applies one word to the shadow store and returns the rsp it should give
  function automatic rsp_t queue_step(req_t w);
    rsp_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    if (w.func == FUNC_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        // new key lands ahead of equal keys
        while (pos < shadow_count && shadow_keys[pos] > w.key_in) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[pos] = w.key_in;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (int i = 0; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      r.max_key = shadow_keys[0];
      r.has_max = 1'b1;
    end
    r.entry_total = shadow_count[ENTRY_W-1:0];
    return r;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      3, 4: return $signed($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR: %s got %0h want %0h (rsp word %0d)", what, got, want, words_out);
    mismatches++;
  endtask

  task automatic add_row(func_t f, logic signed [KEY_W-1:0] k, bit pin, rsp_t want);
    row_t r;
    r.w.func = f;
    r.w.key_in = k;
    r.pin = pin;
    r.want = want;
    plan.push_back(r);
  endtask

  task automatic offer(req_t w, bit pin, rsp_t want);
    while ($urandom_range(99) < snd_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    pinned <= pin;
    pinned_rsp <= want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // monitor: predict on req acceptance, check on rsp acceptance
  always @(posedge clk) begin : monitor
    rsp_t nxt;
    rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        nxt = queue_step(req);
        if (nxt.status == ST_FULL) full_hits++;
        if (nxt.status == ST_EMPTY) empty_hits++;
        due_rsp.push_back(pinned ? pinned_rsp : nxt);
        words_in++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          report_mismatch("rsp word with nothing due", 64'(rsp), 64'd0);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.max_key !== want.max_key)
            report_mismatch("max_key", 64'(rsp.max_key), 64'(want.max_key));
          if (rsp.has_max !== want.has_max)
            report_mismatch("has_max", 64'(rsp.has_max), 64'(want.has_max));
          if (rsp.entry_total !== want.entry_total)
            report_mismatch("entry_total", 64'(rsp.entry_total), 64'(want.entry_total));
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
        end
        words_out++;
      end
    end
  end

  // receiver: random stall, plus one long hold-off on request
  initial begin : receiver
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          rsp_stall <= 1'b1;
          @(posedge clk);
        end
      end
      rsp_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    req_t w;
    int ins_pct;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    pinned = 1'b0;
    pinned_rsp = '0;
    hold_req = 1'b0;
    snd_idle = 21;
    rcv_idle = 66;
    shadow_count = 0;
    foreach (shadow_keys[i]) shadow_keys[i] = '0;

    // empty store, extremes, equal keys, ignored key on remove
    add_row(FUNC_REMOVE, 32'sd0, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_EMPTY});
    add_row(FUNC_INSERT, KEY_MAX, 1'b1, '{KEY_MAX, 1'b1, 5'd1, ST_OK});
    add_row(FUNC_INSERT, KEY_MIN, 1'b1, '{KEY_MAX, 1'b1, 5'd2, ST_OK});
    add_row(FUNC_INSERT, KEY_MAX, 1'b1, '{KEY_MAX, 1'b1, 5'd3, ST_OK});
    add_row(FUNC_REMOVE, -32'sd1, 1'b1, '{KEY_MAX, 1'b1, 5'd2, ST_OK});
    add_row(FUNC_REMOVE, 32'sh5A5A_5A5A, 1'b1, '{KEY_MIN, 1'b1, 5'd1, ST_OK});
    add_row(FUNC_REMOVE, 32'sd0, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK});
    // fill to capacity, then one insert too many
    add_row(FUNC_INSERT, 32'sd5, 1'b0, '0);
    add_row(FUNC_INSERT, 32'sd0, 1'b0, '0);
    add_row(FUNC_INSERT, -32'sd1, 1'b0, '0);
    add_row(FUNC_INSERT, 32'sd5, 1'b0, '0);
    add_row(FUNC_INSERT, -32'sd8, 1'b0, '0);
    add_row(FUNC_INSERT, KEY_MIN, 1'b0, '0);
    add_row(FUNC_INSERT, 32'sh1234_5678, 1'b0, '0);
    add_row(FUNC_INSERT, 32'shEDCB_A987, 1'b0, '0);
    add_row(FUNC_INSERT, 32'sd3, 1'b0, '0);
    add_row(FUNC_INSERT, 32'sd3, 1'b0, '0);
    add_row(FUNC_INSERT, 32'sd3, 1'b0, '0);
    add_row(FUNC_INSERT, KEY_MAX, 1'b0, '0);
    add_row(FUNC_INSERT, 32'sd1, 1'b0, '0);
    add_row(FUNC_INSERT, -32'sd2, 1'b0, '0);
    add_row(FUNC_INSERT, 32'sd100, 1'b0, '0);
    add_row(FUNC_INSERT, -32'sd100, 1'b0, '0);
    add_row(FUNC_INSERT, 32'sd7, 1'b1, '{KEY_MAX, 1'b1, 5'd16, ST_FULL});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) offer(plan[i].w, plan[i].pin, plan[i].want);

    ins_pct = 50;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin snd_idle = 21; rcv_idle = 66; end
        1: begin snd_idle = 66; rcv_idle = 21; end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
          // sender keeps offering while the receiver sits on a word
          hold_req = 1'b1;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // runs biased toward filling or draining so both ends get hit
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: ins_pct = 25;
            1: ins_pct = 50;
            default: ins_pct = 80;
          endcase
        end
        w.func = ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
        w.key_in = pick_key();
        offer(w, 1'b0, '0);
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (due_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d req words and %0d rsp words over three idle mixes",
             words_in, words_out);
    $display("inserts refused on a full store: %0d, removes on an empty one: %0d",
             full_hits, empty_hits);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
